// File: src/qspc_pkg.sv
// ----------------------------------------------------------------------------
// qspc_pkg
// Shared types and constants for the quadrature speed PI controller:
// register indexes, configuration record, datapath commands, saturation.
// ----------------------------------------------------------------------------
package qspc_pkg;

  // Configuration port geometry
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_ALPHA  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE   = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD   = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT   = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MAX     = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_PER_VOLT = 8'd7;

  // Register reset values
  localparam logic [23:0] RST_PROP_GAIN     = 24'd6554;
  localparam logic [23:0] RST_INTEG_GAIN    = 24'd19661;
  localparam logic [16:0] RST_FILTER_ALPHA  = 17'd21845;
  localparam logic [23:0] RST_SPEED_SCALE   = 24'd8578660;
  localparam logic [24:0] RST_TICK_PERIOD   = 25'd16777;
  localparam logic [30:0] RST_INTEG_LIMIT   = 31'd655360;
  localparam logic [30:0] RST_DRIVE_MAX     = 31'd720896;
  localparam logic [16:0] RST_DUTY_PER_VOLT = 17'd5461;

  // Fixed scaling of the filter and the integral step
  localparam int unsigned ALPHA_SHIFT = 16;
  localparam int unsigned TICK_SHIFT  = 24;
  localparam logic [16:0] ALPHA_ONE   = 17'h10000;

  // Direction codes
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_REV  = 2'd2;

  // Quadrature step codes (new phase minus old phase, mod 4)
  localparam logic [1:0] STEP_DOWN = 2'd1;
  localparam logic [1:0] STEP_UP   = 2'd3;

  // Shared multiplier: 34 bit signed by 25 bit unsigned
  localparam int unsigned MUL_A_W = 34;
  localparam int unsigned MUL_B_W = 25;
  localparam int unsigned PROD_W  = 60;

  typedef logic signed [PROD_W-1:0] prod_t;

  typedef struct packed {
    logic [23:0] prop_gain;
    logic [23:0] integ_gain;
    logic [16:0] filter_alpha;
    logic [23:0] speed_scale;
    logic [24:0] tick_period;
    logic [30:0] integ_limit;
    logic [30:0] drive_max;
    logic [16:0] duty_per_volt;
  } cfg_t;

  // Datapath commands issued by the sequencer
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_ENC,
    CMD_START,
    CMD_FILT,
    CMD_YUPD,
    CMD_ERR,
    CMD_PROP,
    CMD_INTEG,
    CMD_PTERM,
    CMD_DRIVE,
    CMD_DUTYMUL,
    CMD_DUTY,
    CMD_OUT
  } cmd_e;

  // Saturate a wide signed value to signed 32 bit
  function automatic logic signed [31:0] sat32(input prod_t v);
    logic signed [31:0] r;
    if (v[PROD_W-1:31] == {(PROD_W-31){v[31]}}) begin
      r = v[31:0];
    end else if (v[PROD_W-1]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

// File: src/quadrature_speed_pi_controller_core.sv
// ----------------------------------------------------------------------------
// quadrature_speed_pi_controller_core
// Encoder sample: decoded on accept, result registered from S_OUT once the
// result register is free. Control tick: six dependent products through one
// shared multiplier, with wait states S_WX, S_WF, S_WI, S_WD; one request at a time.
// Reset clears position, speed, integral, drive, duty and loads the gains.
// ----------------------------------------------------------------------------
module quadrature_speed_pi_controller_core #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             func_i,
  input  logic                             enc_a_i,
  input  logic                             enc_b_i,
  input  logic signed [31:0]               target_speed_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [31:0]               position_o,
  output logic [1:0]                       direction_o,
  output logic signed [31:0]               speed_o,
  output logic [30:0]                      drive_o,
  output logic [15:0]                      duty_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [qspc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [qspc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  qspc_pkg::cfg_t cfg;
  qspc_pkg::cmd_e cmd;

  // Configuration registers
  qspc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Sequencer
  qspc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Arithmetic and state
  qspc_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_i          (cfg),
    .enc_a_i        (enc_a_i),
    .enc_b_i        (enc_b_i),
    .target_speed_i (target_speed_i),
    .position_o     (position_o),
    .direction_o    (direction_o),
    .speed_o        (speed_o),
    .drive_o        (drive_o),
    .duty_o         (duty_o)
  );

endmodule

// File: src/qspc_cfg_regs.sv
// ----------------------------------------------------------------------------
// qspc_cfg_regs
// Configuration register file; takes one write request per cycle and
// drops writes to indexes outside the register list.
// ----------------------------------------------------------------------------
module qspc_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [qspc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [qspc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output qspc_pkg::cfg_t                      cfg_o
);

  qspc_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;

  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i & cfg_ready_o;

  // Decode the write request into the addressed field
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (cfg_index_i)
        qspc_pkg::REG_PROP_GAIN:     cfg_d.prop_gain     = cfg_data_i[23:0];
        qspc_pkg::REG_INTEG_GAIN:    cfg_d.integ_gain    = cfg_data_i[23:0];
        qspc_pkg::REG_FILTER_ALPHA:  cfg_d.filter_alpha  = cfg_data_i[16:0];
        qspc_pkg::REG_SPEED_SCALE:   cfg_d.speed_scale   = cfg_data_i[23:0];
        qspc_pkg::REG_TICK_PERIOD:   cfg_d.tick_period   = cfg_data_i[24:0];
        qspc_pkg::REG_INTEG_LIMIT:   cfg_d.integ_limit   = cfg_data_i[30:0];
        qspc_pkg::REG_DRIVE_MAX:     cfg_d.drive_max     = cfg_data_i[30:0];
        qspc_pkg::REG_DUTY_PER_VOLT: cfg_d.duty_per_volt = cfg_data_i[16:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain     <= qspc_pkg::RST_PROP_GAIN;
      cfg_q.integ_gain    <= qspc_pkg::RST_INTEG_GAIN;
      cfg_q.filter_alpha  <= qspc_pkg::RST_FILTER_ALPHA;
      cfg_q.speed_scale   <= qspc_pkg::RST_SPEED_SCALE;
      cfg_q.tick_period   <= qspc_pkg::RST_TICK_PERIOD;
      cfg_q.integ_limit   <= qspc_pkg::RST_INTEG_LIMIT;
      cfg_q.drive_max     <= qspc_pkg::RST_DRIVE_MAX;
      cfg_q.duty_per_volt <= qspc_pkg::RST_DUTY_PER_VOLT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: src/qspc_ctrl.sv
// ----------------------------------------------------------------------------
// qspc_ctrl
// Sequencer: takes one request at a time, steps the datapath through the
// control tick, and owns the result valid flag.
// ----------------------------------------------------------------------------
module qspc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 func_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output qspc_pkg::cmd_e       cmd_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_WX      = 4'd1;
  localparam logic [3:0] S_FILT    = 4'd2;
  localparam logic [3:0] S_WF      = 4'd3;
  localparam logic [3:0] S_YUPD    = 4'd4;
  localparam logic [3:0] S_ERR     = 4'd5;
  localparam logic [3:0] S_PROP    = 4'd6;
  localparam logic [3:0] S_INTEG   = 4'd7;
  localparam logic [3:0] S_PTERM   = 4'd8;
  localparam logic [3:0] S_WI      = 4'd9;
  localparam logic [3:0] S_DRIVE   = 4'd10;
  localparam logic [3:0] S_DUTYMUL = 4'd11;
  localparam logic [3:0] S_WD      = 4'd12;
  localparam logic [3:0] S_DUTY    = 4'd13;
  localparam logic [3:0] S_OUT     = 4'd14;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_acc;
  logic       out_free;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign out_free   = ~out_valid_q | ~out_stall_i;

  // Advance the sequence and issue at most one command per cycle; S_OUT holds while the result register is busy
  always_comb begin
    state_d     = state_q;
    cmd_o       = qspc_pkg::CMD_NONE;
    out_valid_d = out_valid_q & out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (func_i) begin
            cmd_o   = qspc_pkg::CMD_START;
            state_d = S_WX;
          end else begin
            cmd_o   = qspc_pkg::CMD_ENC;
            state_d = S_OUT;
          end
        end
      end
      S_WX:      state_d = S_FILT;
      S_FILT: begin
        cmd_o   = qspc_pkg::CMD_FILT;
        state_d = S_WF;
      end
      S_WF:      state_d = S_YUPD;
      S_YUPD: begin
        cmd_o   = qspc_pkg::CMD_YUPD;
        state_d = S_ERR;
      end
      S_ERR: begin
        cmd_o   = qspc_pkg::CMD_ERR;
        state_d = S_PROP;
      end
      S_PROP: begin
        cmd_o   = qspc_pkg::CMD_PROP;
        state_d = S_INTEG;
      end
      S_INTEG: begin
        cmd_o   = qspc_pkg::CMD_INTEG;
        state_d = S_PTERM;
      end
      S_PTERM: begin
        cmd_o   = qspc_pkg::CMD_PTERM;
        state_d = S_WI;
      end
      S_WI:      state_d = S_DRIVE;
      S_DRIVE: begin
        cmd_o   = qspc_pkg::CMD_DRIVE;
        state_d = S_DUTYMUL;
      end
      S_DUTYMUL: begin
        cmd_o   = qspc_pkg::CMD_DUTYMUL;
        state_d = S_WD;
      end
      S_WD:      state_d = S_DUTY;
      S_DUTY: begin
        cmd_o   = qspc_pkg::CMD_DUTY;
        state_d = S_OUT;
      end
      S_OUT: begin
        // Hold until the result register is free
        if (out_free) begin
          cmd_o       = qspc_pkg::CMD_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: src/qspc_datapath.sv
// ----------------------------------------------------------------------------
// qspc_datapath
// Encoder decode, speed filter and PI loop around one shared registered
// multiplier; each command performs one step of the sequence.
// ----------------------------------------------------------------------------
module qspc_datapath #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  qspc_pkg::cmd_e       cmd_i,
  input  qspc_pkg::cfg_t       cfg_i,
  input  logic                 enc_a_i,
  input  logic                 enc_b_i,
  input  logic signed [31:0]   target_speed_i,
  output logic signed [31:0]   position_o,
  output logic [1:0]           direction_o,
  output logic signed [31:0]   speed_o,
  output logic [30:0]          drive_o,
  output logic [15:0]          duty_o
);

  // Controller state
  logic [1:0]          quad_q;
  logic signed [31:0]  pos_q;
  logic signed [31:0]  pos_tick_q;
  logic [1:0]          dir_q;
  logic signed [31:0]  speed_q;
  logic signed [31:0]  integ_q;
  logic [30:0]         drive_q;
  logic [15:0]         duty_q;

  // Working registers
  logic signed [qspc_pkg::MUL_A_W-1:0] mul_a_q;
  logic [qspc_pkg::MUL_B_W-1:0]        mul_b_q;
  qspc_pkg::prod_t                     prod_q;
  logic signed [31:0]                  target_q;
  logic signed [32:0]                  err_q;
  qspc_pkg::prod_t                     pterm_q;

  // Step results
  logic [1:0]          phase;
  logic [1:0]          step;
  logic signed [31:0]  delta;
  logic signed [31:0]  x_sat;
  logic signed [32:0]  diff;
  logic [16:0]         alpha_c;
  qspc_pkg::prod_t     y_sum;
  logic signed [32:0]  err;
  qspc_pkg::prod_t     integ_sum;
  qspc_pkg::prod_t     integ_lim;
  qspc_pkg::prod_t     integ_clip;
  qspc_pkg::prod_t     drv_sum;
  qspc_pkg::prod_t     drv_max;
  logic [30:0]         drv_clip;
  qspc_pkg::prod_t     duty_full;
  logic [15:0]         duty_sat;

  // Binary phase decoded from the Gray-coded pins and step against the stored phase
  assign phase = {enc_a_i, enc_a_i ^ enc_b_i};
  assign step  = phase - quad_q;

  // Tick arithmetic, one piece per command
  assign delta      = pos_q - pos_tick_q;
  assign x_sat      = qspc_pkg::sat32(prod_q);
  assign diff       = 33'(x_sat) - 33'(speed_q);
  assign alpha_c    = cfg_i.filter_alpha[16] ? qspc_pkg::ALPHA_ONE : cfg_i.filter_alpha;
  assign y_sum      = qspc_pkg::prod_t'(speed_q) + (prod_q >>> qspc_pkg::ALPHA_SHIFT);
  assign err        = 33'(target_q) - 33'(speed_q);
  assign integ_sum  = qspc_pkg::prod_t'(integ_q) + (prod_q >>> qspc_pkg::TICK_SHIFT);
  assign integ_lim  = $signed({{(qspc_pkg::PROD_W-31){1'b0}}, cfg_i.integ_limit});
  assign integ_clip = (integ_sum > integ_lim) ? integ_lim : integ_sum;
  assign drv_sum    = pterm_q + (prod_q >>> FRAC_BITS);
  assign drv_max    = $signed({{(qspc_pkg::PROD_W-31){1'b0}}, cfg_i.drive_max});
  assign duty_full  = prod_q >>> FRAC_BITS;
  assign duty_sat   = (|duty_full[qspc_pkg::PROD_W-1:16]) ? 16'hFFFF : duty_full[15:0];

  // Clamp the drive to zero .. drive_max
  always_comb begin
    if (drv_sum[qspc_pkg::PROD_W-1]) begin
      drv_clip = '0;
    end else if (drv_sum > drv_max) begin
      drv_clip = cfg_i.drive_max;
    end else begin
      drv_clip = drv_sum[30:0];
    end
  end

  // Shared multiplier, registered every cycle
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a_q * $signed({1'b0, mul_b_q});
  end

  // Load multiplier operands and working values
  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      qspc_pkg::CMD_START: begin
        target_q <= target_speed_i;
        mul_a_q  <= qspc_pkg::MUL_A_W'(delta);
        mul_b_q  <= qspc_pkg::MUL_B_W'(cfg_i.speed_scale);
      end
      qspc_pkg::CMD_FILT: begin
        mul_a_q <= qspc_pkg::MUL_A_W'(diff);
        mul_b_q <= qspc_pkg::MUL_B_W'(alpha_c);
      end
      qspc_pkg::CMD_ERR: begin
        err_q   <= err;
        mul_a_q <= qspc_pkg::MUL_A_W'(err);
        mul_b_q <= cfg_i.tick_period;
      end
      qspc_pkg::CMD_PROP: begin
        mul_a_q <= qspc_pkg::MUL_A_W'(err_q);
        mul_b_q <= qspc_pkg::MUL_B_W'(cfg_i.prop_gain);
      end
      qspc_pkg::CMD_PTERM: begin
        pterm_q <= prod_q >>> FRAC_BITS;
        mul_a_q <= qspc_pkg::MUL_A_W'(integ_q);
        mul_b_q <= qspc_pkg::MUL_B_W'(cfg_i.integ_gain);
      end
      qspc_pkg::CMD_DUTYMUL: begin
        mul_a_q <= $signed({3'b000, drive_q});
        mul_b_q <= qspc_pkg::MUL_B_W'(cfg_i.duty_per_volt);
      end
      default: begin
        mul_a_q <= mul_a_q;
      end
    endcase
  end

  // Update the controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quad_q     <= '0;
      pos_q      <= '0;
      pos_tick_q <= '0;
      dir_q      <= qspc_pkg::DIR_NONE;
      speed_q    <= '0;
      integ_q    <= '0;
      drive_q    <= '0;
      duty_q     <= '0;
    end else begin
      unique case (cmd_i)
        qspc_pkg::CMD_ENC: begin
          quad_q <= phase;
          if (step == qspc_pkg::STEP_DOWN) begin
            pos_q <= pos_q - 32'sd1;
            dir_q <= qspc_pkg::DIR_REV;
          end else if (step == qspc_pkg::STEP_UP) begin
            pos_q <= pos_q + 32'sd1;
            dir_q <= qspc_pkg::DIR_FWD;
          end
        end
        qspc_pkg::CMD_START: pos_tick_q <= pos_q;
        qspc_pkg::CMD_YUPD:  speed_q    <= qspc_pkg::sat32(y_sum);
        qspc_pkg::CMD_INTEG: integ_q    <= qspc_pkg::sat32(integ_clip);
        qspc_pkg::CMD_DRIVE: drive_q    <= drv_clip;
        qspc_pkg::CMD_DUTY:  duty_q     <= duty_sat;
        default:             quad_q     <= quad_q;
      endcase
    end
  end

  // Capture the result
  always_ff @(posedge clk_i) begin
    if (cmd_i == qspc_pkg::CMD_OUT) begin
      position_o  <= pos_q;
      direction_o <= dir_q;
      speed_o     <= speed_q;
      drive_o     <= drive_q;
      duty_o      <= duty_q;
    end
  end

endmodule

// File: src/qspc_checker.sv
// ----------------------------------------------------------------------------
// qspc_checker
// Port-level checks of the controller core, bound to the top level.
// ----------------------------------------------------------------------------
module qspc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic                             func_i,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic signed [31:0]               position_o,
  input logic [1:0]                       direction_o,
  input logic signed [31:0]               speed_o,
  input logic [30:0]                      drive_o,
  input logic [15:0]                      duty_o
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(position_o)
      && $stable(speed_o) && $stable(drive_o) && $stable(duty_o))
    else $error("stalled result changed");

  // One request at a time: stall right after every accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while busy");

  // Zero drive gives zero duty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && drive_o == 31'd0 |-> duty_o == 16'd0)
    else $error("duty without drive");

  // Direction code never shows the unused value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> direction_o != 2'd3)
    else $error("bad direction code");

  // Encoder sample passes straight through S_OUT to its result when the output is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !func_i && !out_valid_o |=> ##1 out_valid_o)
    else $error("encoder result late");

endmodule

bind quadrature_speed_pi_controller_core qspc_checker u_checker (.*);
